// ===== src/skng_pkg.sv =====
// ============================================================================
// skng_pkg
// Shared types, constants and the note-to-key table of the key scan note gate.
// ============================================================================
package skng_pkg;

    // default sizes of the keyboard and voice array
    localparam int NUM_NOTES_DEF = 12;
    localparam int NUM_KEYS_DEF  = 18;

    // field widths
    localparam int KEY_IDX_W = 5;
    localparam int TICK_W    = 16;
    localparam int WCNT_W    = 4;
    localparam int WAVE_W    = 3;
    localparam int OCT_W     = 3;
    localparam int MASK_W    = 12;
    localparam int ACT_W     = 4;
    localparam int SUM_W     = 5;
    localparam int M_DATA_W  = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // control keys
    localparam int KEY_WAVE_DOWN = 15;
    localparam int KEY_WAVE_UP   = 13;
    localparam int KEY_OCT_DOWN  = 8;
    localparam int KEY_OCT_UP    = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_TOP     = 2'd2;

    // configuration reset values
    localparam logic [TICK_W-1:0] RELEASE_TICKS_RST  = 16'd1600;
    localparam logic [WCNT_W-1:0] WAVEFORM_COUNT_RST = 4'd6;
    localparam logic [OCT_W-1:0]  OCTAVE_TOP_RST     = 3'd7;

    // word request kinds (s_tuser)
    localparam logic REQ_SCAN   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // per-key event of one scan
    typedef struct packed {
        logic click;
        logic release_evt;
    } key_evt_t;

    // per-note gate status
    typedef struct packed {
        logic on;
        logic fading;
    } note_stat_t;

    // clicks on the control keys
    typedef struct packed {
        logic wave_down;
        logic wave_up;
        logic oct_down;
        logic oct_up;
    } ctrl_click_t;

    // key that drives each note; notes past the twelfth sit on an unscanned key
    function automatic logic [KEY_IDX_W-1:0] note_key(input int j);
        logic [KEY_IDX_W-1:0] k;
        case (j)
            0:       k = 5'd0;
            1:       k = 5'd2;
            2:       k = 5'd1;
            3:       k = 5'd3;
            4:       k = 5'd5;
            5:       k = 5'd6;
            6:       k = 5'd9;
            7:       k = 5'd10;
            8:       k = 5'd11;
            9:       k = 5'd14;
            10:      k = 5'd12;
            11:      k = 5'd16;
            default: k = 5'd31;
        endcase
        return k;
    endfunction

endpackage

// ===== src/skng_key_lane.sv =====
// ============================================================================
// skng_key_lane
// One key: arm / click / release qualification on each scan word.
// ============================================================================
module skng_key_lane
    import skng_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     scan_fire,
    input  logic     level,
    output key_evt_t evt
);

    logic armed_reg, armed_next;
    logic held_reg, held_next;

    always_comb begin
        evt.click       = scan_fire & level & armed_reg;
        evt.release_evt = scan_fire & ~level & held_reg;
        armed_next = armed_reg;
        held_next  = held_reg;
        if (evt.click) begin
            armed_next = 1'b0;
            held_next  = 1'b1;
        end else if (scan_fire && level && !held_reg) begin
            armed_next = 1'b1;
        end else if (evt.release_evt) begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            held_reg  <= 1'b0;
        end else begin
            armed_reg <= armed_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== src/skng_note_lane.sv =====
// ============================================================================
// skng_note_lane
// One voice gate: on / release phase and its saturating tick counter.
// ============================================================================
module skng_note_lane
    import skng_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  key_evt_t          evt,
    input  logic              sample_fire,
    input  logic [TICK_W-1:0] release_ticks,
    output note_stat_t        stat_next
);

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    note_stat_t        stat_reg;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [TICK_W-1:0] t_on;
    logic [TICK_W-1:0] t_fade;

    always_comb begin
        stat_next  = stat_reg;
        ticks_next = ticks_reg;
        t_on   = (stat_reg.on && ticks_reg != TICK_MAX) ? ticks_reg + 1'b1 : ticks_reg;
        t_fade = (t_on != TICK_MAX) ? t_on + 1'b1 : t_on;
        if (evt.click) begin
            stat_next.on     = 1'b1;
            stat_next.fading = 1'b0;
        end else if (evt.release_evt) begin
            stat_next.on     = 1'b0;
            stat_next.fading = 1'b1;
            ticks_next       = '0;
        end else if (sample_fire) begin
            ticks_next = t_on;
            if (stat_reg.fading) begin
                ticks_next = t_fade;
                if (t_fade > release_ticks) begin
                    ticks_next       = '0;
                    stat_next.fading = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg  <= '0;
            ticks_reg <= '0;
        end else begin
            stat_reg  <= stat_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// ===== src/skng_merge.sv =====
// ============================================================================
// skng_merge
// Waveform / octave selectors, note masks and count, result output register.
// ============================================================================
module skng_merge
    import skng_pkg::*;
#(
    parameter int NUM_NOTES = NUM_NOTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  ctrl_click_t         clicks,
    input  note_stat_t          stat_next [NUM_NOTES],
    input  logic [WCNT_W-1:0]   waveform_count,
    input  logic [OCT_W-1:0]    octave_top,
    output logic                in_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [WAVE_W-1:0]    wave_reg, wave_next, wave_mid;
    logic [OCT_W-1:0]     oct_reg, oct_next, oct_mid;
    logic [WCNT_W-1:0]    wcnt;
    logic [OCT_W-1:0]     otop;
    logic [WCNT_W-1:0]    w_up;
    logic [OCT_W:0]       o_up;
    logic [OCT_W-1:0]     o_dn;
    logic [NUM_NOTES-1:0] play_vec, fade_vec;
    logic [MASK_W+NUM_NOTES-1:0] play_ext, fade_ext;
    logic [SUM_W-1:0]     sum;
    logic [ACT_W-1:0]     active;
    logic                 valid_reg, valid_next;
    logic [M_DATA_W-1:0]  data_reg, data_next;

    // selector stepping, lower key index first
    always_comb begin
        wcnt = (waveform_count == '0) ? WCNT_W'(1)
             : (waveform_count > WCNT_W'(8)) ? WCNT_W'(8) : waveform_count;
        otop = (octave_top == '0) ? OCT_W'(1) : octave_top;

        wave_mid = wave_reg;
        w_up     = {1'b0, wave_reg} + 1'b1;
        if (clicks.wave_up) begin
            wave_mid = (w_up >= wcnt) ? '0 : w_up[WAVE_W-1:0];
        end
        wave_next = wave_mid;
        if (clicks.wave_down) begin
            wave_next = (wave_mid == '0) ? WAVE_W'(wcnt - 1'b1) : wave_mid - 1'b1;
        end

        oct_mid = oct_reg;
        o_up    = {1'b0, oct_reg} + 1'b1;
        if (clicks.oct_up) begin
            oct_mid = (o_up > {1'b0, otop}) ? OCT_W'(1) : o_up[OCT_W-1:0];
        end
        oct_next = oct_mid;
        o_dn     = (oct_mid == '0) ? '0 : oct_mid - 1'b1;
        if (clicks.oct_down) begin
            oct_next = (o_dn == '0) ? otop : o_dn;
        end
    end

    // note masks and active count
    always_comb begin
        sum = '0;
        for (int j = 0; j < NUM_NOTES; j++) begin
            play_vec[j] = stat_next[j].on;
            fade_vec[j] = stat_next[j].fading;
            sum = sum + SUM_W'(stat_next[j].on | stat_next[j].fading);
        end
        play_ext = {{MASK_W{1'b0}}, play_vec};
        fade_ext = {{MASK_W{1'b0}}, fade_vec};
        active   = sum[SUM_W-1] ? '1 : sum[ACT_W-1:0];
    end

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_fire) begin
            valid_next = 1'b1;
            data_next  = {6'd0, active, fade_ext[MASK_W-1:0], play_ext[MASK_W-1:0],
                          oct_next, wave_next};
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg  <= '0;
            oct_reg   <= OCT_W'(1);
            valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                wave_reg <= wave_next;
                oct_reg  <= oct_next;
            end
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== src/synth_key_scan_note_gate.sv =====
// ============================================================================
// synth_key_scan_note_gate
// Keyboard scan and note gate controller for a multi-voice synthesizer.
// ============================================================================
// result: a word's result is registered and on m_tdata in the cycle after it is accepted
// throughput: one word per cycle; all key and note lanes update in that cycle,
//   a new word is taken in the cycle the waiting result leaves, a stalled
//   result stalls the input
// reset: aresetn synchronous, active low; clears keys, gates, counters and
//   selectors, loads register defaults, no clearing pass needed
// ============================================================================
module synth_key_scan_note_gate
    import skng_pkg::*;
#(
    parameter int NUM_NOTES = NUM_NOTES_DEF,
    parameter int NUM_KEYS  = NUM_KEYS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((NUM_KEYS+7)/8)*8-1:0] s_tdata,   // key_levels
    input  logic                          s_tuser,   // req_type
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // waveform_sel, octave, playing_mask, releasing_mask, active_notes
    output logic [M_DATA_W-1:0]           m_tdata,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    logic [TICK_W-1:0] release_ticks_reg;
    logic [WCNT_W-1:0] waveform_count_reg;
    logic [OCT_W-1:0]  octave_top_reg;

    logic        in_fire;
    logic        scan_fire;
    logic        sample_fire;
    key_evt_t    key_evt   [NUM_KEYS];
    note_stat_t  stat_next [NUM_NOTES];
    ctrl_click_t clicks;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            release_ticks_reg  <= RELEASE_TICKS_RST;
            waveform_count_reg <= WAVEFORM_COUNT_RST;
            octave_top_reg     <= OCTAVE_TOP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RELEASE_TICKS:  release_ticks_reg  <= cfg_data;
                CFG_WAVEFORM_COUNT: waveform_count_reg <= cfg_data[WCNT_W-1:0];
                CFG_OCTAVE_TOP:     octave_top_reg     <= cfg_data[OCT_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_fire     = s_tvalid && s_tready;
    assign scan_fire   = in_fire && (s_tuser == REQ_SCAN);
    assign sample_fire = in_fire && (s_tuser == REQ_SAMPLE);

    // one lane per key
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        skng_key_lane u_key (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .scan_fire (scan_fire),
            .level     (s_tdata[k]),
            .evt       (key_evt[k])
        );
    end

    // one lane per note, fed by the key it is mapped to
    for (genvar j = 0; j < NUM_NOTES; j++) begin : g_note
        localparam int NK = int'(note_key(j));
        key_evt_t note_evt;
        if (NK < NUM_KEYS) begin : g_mapped
            assign note_evt = key_evt[NK];
        end else begin : g_unmapped
            // key is never scanned
            assign note_evt = '0;
        end
        skng_note_lane u_note (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .evt           (note_evt),
            .sample_fire   (sample_fire),
            .release_ticks (release_ticks_reg),
            .stat_next     (stat_next[j])
        );
    end

    // control keys that exist on this keyboard
    if (KEY_WAVE_DOWN < NUM_KEYS) begin : g_wd
        assign clicks.wave_down = key_evt[KEY_WAVE_DOWN].click;
    end else begin : g_wd_n
        assign clicks.wave_down = 1'b0;
    end
    if (KEY_WAVE_UP < NUM_KEYS) begin : g_wu
        assign clicks.wave_up = key_evt[KEY_WAVE_UP].click;
    end else begin : g_wu_n
        assign clicks.wave_up = 1'b0;
    end
    if (KEY_OCT_DOWN < NUM_KEYS) begin : g_od
        assign clicks.oct_down = key_evt[KEY_OCT_DOWN].click;
    end else begin : g_od_n
        assign clicks.oct_down = 1'b0;
    end
    if (KEY_OCT_UP < NUM_KEYS) begin : g_ou
        assign clicks.oct_up = key_evt[KEY_OCT_UP].click;
    end else begin : g_ou_n
        assign clicks.oct_up = 1'b0;
    end

    // selectors, masks, count and the result register
    skng_merge #(
        .NUM_NOTES (NUM_NOTES)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_fire        (in_fire),
        .clicks         (clicks),
        .stat_next      (stat_next),
        .waveform_count (waveform_count_reg),
        .octave_top     (octave_top_reg),
        .in_ready       (s_tready),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

// ===== src/skng_checker.sv =====
// ============================================================================
// skng_checker
// Port-level checks on the result words of the key scan note gate.
// ============================================================================
module skng_checker
    import skng_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a note is never both sounding and releasing
    a_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:6] & m_tdata[29:18]) == 12'd0)
        else $error("note both playing and releasing");

    // count agrees with the masks
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:30] == 4'($countones(m_tdata[17:6] | m_tdata[29:18])))
        else $error("active note count does not match masks");

    // octave never reads zero
    a_octave: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:3] != 3'd0)
        else $error("octave is zero");

endmodule

bind synth_key_scan_note_gate skng_checker u_skng_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
